// ===== design/rdss_pkg.sv =====
`timescale 1ns / 1ps
package rdss_pkg;

  // default sizes
  localparam int NUM_SETS_DEF      = 2048;
  localparam int NUM_WAYS_DEF      = 16;
  localparam int REUSE_ENTRIES_DEF = 2048;
  localparam int LEADER_SETS_DEF   = 64;
  localparam int ADDR_BITS_DEF     = 48;

  // fixed field widths
  localparam int SET_IDX_W = 11;
  localparam int WAY_W     = 4;
  localparam int MASK_W    = 16;
  localparam int PC_W      = 64;
  localparam int PADDR_W   = 48;
  localparam int SCORE_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [16:0] SWEEP_PERIOD = 17'd100000;
  localparam logic [9:0]  PSEL_INIT    = 10'd512;
  localparam logic [9:0]  PSEL_MAX     = 10'd1023;
  localparam logic [7:0]  SCORE_MAX    = 8'd255;

  localparam logic [7:0]            THRESH_RST     = 8'd32;
  localparam logic [PADDR_W-1:0]    STRIDE_MIN_RST = 48'd64;
  localparam logic [PADDR_W-1:0]    STRIDE_MAX_RST = 48'd1024;

  localparam logic [1:0] RRPV_DISTANT = 2'd3;
  localparam logic [1:0] RRPV_LONG    = 2'd2;
  localparam logic [1:0] RRPV_NEAR    = 2'd0;
  localparam logic [1:0] REUSE_INIT   = 2'd1;
  localparam logic [1:0] REUSE_MAX    = 2'd3;
  localparam logic [1:0] REUSE_HOT    = 2'd2;

  typedef enum logic {
    OP_VICTIM,
    OP_UPDATE
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESH,
    CFG_STRIDE_MIN,
    CFG_STRIDE_MAX
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_t;

endpackage

// ===== design/rdss_req_if.sv =====
`timescale 1ns / 1ps
interface rdss_req_if import rdss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [SET_IDX_W-1:0] set_index;
  logic [WAY_W-1:0]     way_index;
  logic [MASK_W-1:0]    valid_mask;
  logic [PC_W-1:0]      pc;
  logic [PADDR_W-1:0]   paddr;
  logic                 hit;

  modport source(output valid, opcode, set_index, way_index, valid_mask, pc, paddr, hit,
                 input ready);
  modport sink(input valid, opcode, set_index, way_index, valid_mask, pc, paddr, hit,
               output ready);
endinterface

// ===== design/rdss_res_if.sv =====
`timescale 1ns / 1ps
interface rdss_res_if import rdss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WAY_W-1:0] victim_way;

  modport source(output valid, victim_way, input ready);
  modport sink(input valid, victim_way, output ready);
endinterface

// ===== design/rdss_victim.sv =====
`timescale 1ns / 1ps
module rdss_victim import rdss_pkg::*; #(
  parameter int NUM_WAYS = NUM_WAYS_DEF
) (
  input  logic [NUM_WAYS*2-1:0] row,
  input  logic [MASK_W-1:0]     valid_mask,
  output logic [WAY_W-1:0]      way,
  output logic [NUM_WAYS*2-1:0] aged_row
);

  logic [NUM_WAYS-1:0] hi;
  logic [NUM_WAYS-1:0] lo;
  logic [1:0]          top;
  logic [1:0]          add;
  logic                found_inv;
  logic                found_hot;
  logic [WAY_W-1:0]    inv_way;
  logic [WAY_W-1:0]    hot_way;

  // largest rrpv of the set from bit reductions
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      hi[w] = row[2*w+1];
      lo[w] = row[2*w];
    end
    if (|(hi & lo)) top = 2'd3;
    else if (|hi) top = 2'd2;
    else if (|lo) top = 2'd1;
    else top = 2'd0;
    add = RRPV_DISTANT - top;
  end

  // first invalid way, else age and take first distant way
  always_comb begin
    found_inv = 1'b0;
    inv_way   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (w < MASK_W && !found_inv) begin
        if (!valid_mask[w]) begin
          found_inv = 1'b1;
          inv_way   = WAY_W'(w);
        end
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged_row[2*w +: 2] = found_inv ? row[2*w +: 2] : row[2*w +: 2] + add;
    end
    found_hot = 1'b0;
    hot_way   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found_hot && (row[2*w +: 2] + add) == RRPV_DISTANT) begin
        found_hot = 1'b1;
        hot_way   = WAY_W'(w);
      end
    end
    way = found_inv ? inv_way : hot_way;
  end

endmodule

// ===== design/rrip_dueling_ship_stream_replacement.sv =====
`timescale 1ns / 1ps
// Replacement engine for a set-associative last-level cache.
// Requests arrive on the req channel (valid/ready); an opcode of victim
// returns one beat on the res channel with the way to evict, an update
// returns nothing. The user must write the config registers (threshold,
// stride bounds) via cfg_we/cfg_index/cfg_data only while the block is idle (unchecked).
// Per-set state (rrpv row, stream score, last address) sits in one memory,
// the reuse counters in a second; each request is one read, one
// modify-and-write-back.
// A request is taken in the idle cycle and the memories are read at that
// edge; the execute state then writes back and, for a victim, registers the beat.
// A new request is taken only back in the idle state, after the
// read-modify-write of the set memory for the last one.
// Reset: a clearing pass over max(NUM_SETS, REUSE_ENTRIES) entries (2048 by
// default) writes reset values into both memories; ready stays low until done.
// Every 100000th update starts a decay sweep with ready low over
// max(NUM_SETS, REUSE_ENTRIES) entries.
// A stalled res channel holds its beat; a later victim request waits in its
// execute cycle until the beat is taken.
// REUSE_ENTRIES must be a power of two; the block itself does not enforce it.
module rrip_dueling_ship_stream_replacement import rdss_pkg::*; #(
  parameter int NUM_SETS      = NUM_SETS_DEF,
  parameter int NUM_WAYS      = NUM_WAYS_DEF,
  parameter int REUSE_ENTRIES = REUSE_ENTRIES_DEF,
  parameter int LEADER_SETS   = LEADER_SETS_DEF,
  parameter int ADDR_BITS     = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  rdss_req_if.sink              req,
  rdss_res_if.source            res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SET_W      = $clog2(NUM_SETS);
  localparam int RE_W       = $clog2(REUSE_ENTRIES);
  localparam int ROW_W      = NUM_WAYS * 2;
  localparam int WORD_W     = PADDR_W + SCORE_W + ROW_W;
  localparam int SWEEP_LEN  = (NUM_SETS > REUSE_ENTRIES) ? NUM_SETS : REUSE_ENTRIES;
  localparam int CNT_W      = $clog2(SWEEP_LEN + 1);
  localparam int FOLD_W     = (SET_W + 1 > SET_IDX_W + 1) ? SET_W + 1 : SET_IDX_W + 1;
  localparam logic [PADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= PADDR_W) ? {PADDR_W{1'b1}} : PADDR_W'((65'd1 << ADDR_BITS) - 65'd1);

  // memories
  logic [WORD_W-1:0] set_mem [NUM_SETS];
  logic [1:0]        reuse_mem [REUSE_ENTRIES];

  logic              set_re, set_we, reuse_re, reuse_we;
  logic [SET_W-1:0]  set_raddr, set_waddr;
  logic [RE_W-1:0]   reuse_raddr, reuse_waddr;
  logic [WORD_W-1:0] set_wdata, set_rd;
  logic [1:0]        reuse_wdata, reuse_rd;

  // control and request registers
  state_t               state, state_next;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_m1;
  op_t                  op_q;
  logic [SET_W-1:0]     set_q;
  logic [WAY_W-1:0]     way_q;
  logic [MASK_W-1:0]    mask_q;
  logic [PADDR_W-1:0]   addr_q;
  logic                 hit_q;
  logic [RE_W-1:0]      reuse_raddr_q;
  logic [7:0]           thresh;
  logic [PADDR_W-1:0]   stride_min;
  logic [PADDR_W-1:0]   stride_max;
  logic [9:0]           psel;
  logic [16:0]          upd_cnt;
  logic                 res_valid;
  logic [WAY_W-1:0]     res_way;

  logic                 accept, stall, sweep_hit;
  logic [PC_W-1:0]      pc_hash;
  logic [PADDR_W-1:0]   last, stride_gap;
  logic [SCORE_W-1:0]   score, score_new;
  logic [ROW_W-1:0]     row, row_upd, aged_row;
  logic [1:0]           reuse_new, ins;
  logic [16:0]          cnt_inc;
  logic                 srrip_leader, brrip_leader, srrip_sel;
  logic [WAY_W-1:0]     vic_way;

  function automatic logic [SET_W-1:0] set_fold(logic [SET_IDX_W-1:0] s);
    logic [FOLD_W-1:0] v;
    v = FOLD_W'(s);
    for (int k = 0; k < 8; k++) begin
      if (v >= FOLD_W'(NUM_SETS)) v = v - FOLD_W'(NUM_SETS);
    end
    return v[SET_W-1:0];
  endfunction

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign res.valid = res_valid;
  assign res.victim_way = res_way;
  assign stall     = (op_q == OP_VICTIM) && res_valid && !res.ready;
  assign pc_hash   = req.pc ^ (req.pc >> 11) ^ (req.pc >> 21);
  assign cnt_m1    = cnt - CNT_W'(1);

  // memory ports
  always_ff @(posedge clk) begin
    if (set_we) set_mem[set_waddr] <= set_wdata;
    if (set_re) set_rd <= set_mem[set_raddr];
  end

  always_ff @(posedge clk) begin
    if (reuse_we) reuse_mem[reuse_waddr] <= reuse_wdata;
    if (reuse_re) reuse_rd <= reuse_mem[reuse_raddr];
  end

  // victim choice
  rdss_victim #(.NUM_WAYS(NUM_WAYS)) u_victim (
    .row       (row),
    .valid_mask(mask_q),
    .way       (vic_way),
    .aged_row  (aged_row)
  );

  // update datapath
  always_comb begin
    last  = set_rd[WORD_W-1 -: PADDR_W];
    score = set_rd[ROW_W +: SCORE_W];
    row   = set_rd[ROW_W-1:0];
    if (last == '0) stride_gap = '0;
    else if (addr_q >= last) stride_gap = addr_q - last;
    else stride_gap = last - addr_q;
    if (stride_gap >= stride_min && stride_gap <= stride_max)
      score_new = (score != SCORE_MAX) ? score + 8'd1 : score;
    else
      score_new = (score != '0) ? score - 8'd1 : score;
    if (hit_q) reuse_new = (reuse_rd != REUSE_MAX) ? reuse_rd + 2'd1 : reuse_rd;
    else reuse_new = (reuse_rd != '0) ? reuse_rd - 2'd1 : reuse_rd;
    cnt_inc      = upd_cnt + 17'd1;
    sweep_hit    = (cnt_inc == SWEEP_PERIOD);
    srrip_leader = int'(set_q) < LEADER_SETS;
    brrip_leader = !srrip_leader && (int'(set_q) >= NUM_SETS - LEADER_SETS);
    if (srrip_leader) srrip_sel = 1'b1;
    else if (brrip_leader) srrip_sel = 1'b0;
    else srrip_sel = (psel >= PSEL_INIT);
    if (hit_q) ins = RRPV_NEAR;
    else if (score_new >= thresh) ins = RRPV_DISTANT;
    else if (reuse_new >= REUSE_HOT) ins = RRPV_NEAR;
    else if (srrip_sel) ins = RRPV_LONG;
    else ins = (cnt_inc[4:0] == 5'd0) ? RRPV_DISTANT : RRPV_LONG;
    row_upd = row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (int'(way_q) == w) row_upd[2*w +: 2] = ins;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (cnt == CNT_W'(SWEEP_LEN - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_EXEC;
      ST_EXEC: begin
        if (!stall) begin
          if (op_q == OP_UPDATE && sweep_hit) state_next = ST_SWEEP;
          else state_next = ST_IDLE;
        end
      end
      ST_SWEEP: if (cnt == CNT_W'(SWEEP_LEN)) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // memory controls per state
  always_comb begin
    set_re      = 1'b0;
    set_raddr   = '0;
    set_we      = 1'b0;
    set_waddr   = '0;
    set_wdata   = '0;
    reuse_re    = 1'b0;
    reuse_raddr = '0;
    reuse_we    = 1'b0;
    reuse_waddr = '0;
    reuse_wdata = '0;
    case (state)
      ST_CLEAR: begin
        set_we      = cnt < CNT_W'(NUM_SETS);
        set_waddr   = cnt[SET_W-1:0];
        set_wdata   = {{PADDR_W{1'b0}}, {SCORE_W{1'b0}}, {NUM_WAYS{RRPV_DISTANT}}};
        reuse_we    = cnt < CNT_W'(REUSE_ENTRIES);
        reuse_waddr = cnt[RE_W-1:0];
        reuse_wdata = REUSE_INIT;
      end
      ST_IDLE: begin
        set_re      = accept;
        set_raddr   = set_fold(req.set_index);
        reuse_re    = accept;
        reuse_raddr = pc_hash[RE_W-1:0];
      end
      ST_EXEC: begin
        if (!stall) begin
          set_we    = 1'b1;
          set_waddr = set_q;
          if (op_q == OP_VICTIM) set_wdata = {last, score, aged_row};
          else set_wdata = {addr_q, score_new, row_upd};
          reuse_we    = (op_q == OP_UPDATE);
          reuse_waddr = reuse_raddr_q;
          reuse_wdata = reuse_new;
        end
      end
      ST_SWEEP: begin
        set_re      = cnt < CNT_W'(NUM_SETS);
        set_raddr   = cnt[SET_W-1:0];
        reuse_re    = cnt < CNT_W'(REUSE_ENTRIES);
        reuse_raddr = cnt[RE_W-1:0];
        set_we      = (cnt != '0) && (cnt_m1 < CNT_W'(NUM_SETS));
        set_waddr   = cnt_m1[SET_W-1:0];
        set_wdata   = {last, 1'b0, score[SCORE_W-1:1], row};
        reuse_we    = (cnt != '0) && (cnt_m1 < CNT_W'(REUSE_ENTRIES));
        reuse_waddr = cnt_m1[RE_W-1:0];
        reuse_wdata = (reuse_rd != '0) ? reuse_rd - 2'd1 : reuse_rd;
      end
      default: ;
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q          <= op_t'(req.opcode);
      set_q         <= set_fold(req.set_index);
      way_q         <= req.way_index;
      mask_q        <= req.valid_mask;
      addr_q        <= req.paddr & ADDR_MASK;
      hit_q         <= req.hit;
      reuse_raddr_q <= pc_hash[RE_W-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cnt        <= '0;
      psel       <= PSEL_INIT;
      upd_cnt    <= '0;
      res_valid  <= 1'b0;
      thresh     <= THRESH_RST;
      stride_min <= STRIDE_MIN_RST;
      stride_max <= STRIDE_MAX_RST;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR || state == ST_SWEEP) cnt <= cnt + CNT_W'(1);
      else cnt <= '0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESH:     thresh     <= cfg_data[7:0];
          CFG_STRIDE_MIN: stride_min <= cfg_data;
          CFG_STRIDE_MAX: stride_max <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_EXEC && !stall && op_q == OP_UPDATE) begin
        upd_cnt <= sweep_hit ? 17'd0 : cnt_inc;
        if (hit_q && srrip_leader && psel != PSEL_MAX) psel <= psel + 10'd1;
        else if (hit_q && brrip_leader && psel != 10'd0) psel <= psel - 10'd1;
      end
      if (state == ST_EXEC && !stall && op_q == OP_VICTIM) res_valid <= 1'b1;
      else if (res.ready) res_valid <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && !stall && op_q == OP_VICTIM) res_way <= vic_way;
  end

`ifndef SYNTHESIS
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && !stall) |=> state != ST_EXEC)
    else $error("execute cycle repeated without stall");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    upd_cnt < SWEEP_PERIOD)
    else $error("update count out of range");

  a_res_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_EXEC && $past(op_q) == OP_VICTIM)
    else $error("result beat without victim execute");
`endif

endmodule
